### sv/qph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types and constants of the quadratic probing hash table.
// ----------------------------------------------------------------------------
package qph_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int KEY_W     = 31;
    localparam int VAL_W     = 32;
    localparam int SIZE_W    = 11;
    localparam int CNT_W     = 32;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(1024);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DELETED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FOUND    = 3'd5;
    localparam logic [2:0] ST_LIMIT    = 3'd6;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_entry_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_HASH,
        FSM_READ,
        FSM_CHECK,
        FSM_DONE
    } fsm_state_t;

endpackage

### sv/qph_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_mod_unit
// Iterative remainder of a key by the active table size, four bits a cycle.
// ----------------------------------------------------------------------------
module qph_mod_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [qph_pkg::KEY_W-1:0]  dividend,
    input  logic [qph_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [qph_pkg::SIZE_W-1:0] remainder
);
    import qph_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [31:0]       quo_reg, quo_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] div_reg, div_next;
    logic [SIZE_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = {1'b0, dividend};
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // four restoring steps per cycle
            for (int k = 0; k < 4; k++)
            begin
                trial = {rem_next, quo_next[31]};
                if (trial >= {1'b0, div_reg})
                    rem_next = SIZE_W'(trial - {1'b0, div_reg});
                else
                    rem_next = trial[SIZE_W-1:0];
                quo_next = {quo_next[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### sv/qph_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qph_slot_ram
#(
    parameter int DEPTH = qph_pkg::SLOTS_DEF,
    parameter int AW    = 10
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  qph_pkg::slot_entry_t wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output qph_pkg::slot_entry_t rdata
);
    import qph_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/quadratic_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Key-value table with open addressing and quadratic probing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) transfers one operation: mode, key_in,
//   value_in. Output channel (out_valid/out_ready) transfers one result per
//   operation: status, value_out, collision_count, occupancy.
//   cfg_we/cfg_data write table_size at once; write it only while idle.
//   One operation at a time: the accept state, the key modulo table size
//   (start, divider steps at four bits each, done), then per probe a
//   registered read of the slot memory, then check and write back, then
//   the load of the output register. Full and unused-mode results skip
//   hashing.
//   After reset a clearing pass walks the slot memory, one entry a cycle,
//   through all SLOTS entries, with in_ready low.
//   A result waits in the output register while the receiver stalls; the
//   next operation is still accepted and runs up to its own result, then
//   holds until the output register is free.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table
#(
    parameter int SLOTS = qph_pkg::SLOTS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [qph_pkg::SIZE_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 mode,
    input  logic [qph_pkg::KEY_W-1:0]  key_in,
    input  logic signed [qph_pkg::VAL_W-1:0] value_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 status,
    output logic signed [qph_pkg::VAL_W-1:0] value_out,
    output logic [qph_pkg::CNT_W-1:0]  collision_count,
    output logic [qph_pkg::SIZE_W-1:0] occupancy
);
    import qph_pkg::*;

    localparam int AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOTS_CAP = (SLOTS > 2047) ? 2047 : SLOTS;

    fsm_state_t state_reg, state_next;

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] n_act;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [SIZE_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0]  coll_reg, coll_next;

    // operation registers
    logic [1:0]        op_mode_reg, op_mode_next;
    logic [KEY_W-1:0]  op_key_reg, op_key_next;
    logic [VAL_W-1:0]  op_val_reg, op_val_next;
    logic [SIZE_W-1:0] p_reg, p_next;
    logic [SIZE_W-1:0] d_reg, d_next;
    logic [SIZE_W-1:0] i_reg, i_next;
    logic [2:0]        res_st_reg, res_st_next;
    logic [VAL_W-1:0]  res_val_reg, res_val_next;

    // output register
    logic              ov_reg, ov_next;
    logic [2:0]        o_st_reg;
    logic [VAL_W-1:0]  o_val_reg;
    logic [CNT_W-1:0]  o_coll_reg;
    logic [SIZE_W-1:0] o_occ_reg;
    logic              o_load;

    // divider and memory hookup
    logic              div_start;
    logic              div_done;
    logic [SIZE_W-1:0] div_rem;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    slot_entry_t       ram_wdata;
    logic              ram_re;
    slot_entry_t       ram_rdata;

    logic [SIZE_W:0]   p_sum;
    logic [SIZE_W:0]   d_sum;

    // clamp size to one and to the slot count
    always_comb
    begin
        if (size_reg == '0)
            n_act = SIZE_W'(1);
        else if (size_reg > SIZE_W'(SLOTS_CAP))
            n_act = SIZE_W'(SLOTS_CAP);
        else
            n_act = size_reg;
    end

    qph_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (op_key_reg),
        .divisor   (n_act),
        .done      (div_done),
        .remainder (div_rem)
    );

    qph_slot_ram #(.DEPTH(SLOTS), .AW(AW)) u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(p_reg)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        used_next    = used_reg;
        coll_next    = coll_reg;
        op_mode_next = op_mode_reg;
        op_key_next  = op_key_reg;
        op_val_next  = op_val_reg;
        p_next       = p_reg;
        d_next       = d_reg;
        i_next       = i_reg;
        res_st_next  = res_st_reg;
        res_val_next = res_val_reg;
        in_ready     = 1'b0;
        div_start    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = AW'(p_reg);
        ram_wdata    = '{used: 1'b1, key: op_key_reg, value: op_val_reg};
        ram_re       = 1'b0;
        o_load       = 1'b0;
        p_sum        = {1'b0, p_reg} + {1'b0, d_reg};
        d_sum        = {1'b0, d_reg} + (SIZE_W + 1)'(2);

        unique case (state_reg)
            FSM_CLEAR:
            begin
                // sweep the store and mark every slot free
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '{used: 1'b0, key: '0, value: '0};
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(SLOTS - 1))
                    state_next = FSM_IDLE;
            end
            FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_mode_next = mode;
                    op_key_next  = key_in;
                    op_val_next  = value_in;
                    res_val_next = '0;
                    if (mode == MODE_INSERT && used_reg >= n_act)
                    begin
                        res_st_next = ST_FULL;
                        state_next  = FSM_DONE;
                    end
                    else if (mode == MODE_UNUSED)
                    begin
                        res_st_next = ST_NOTFOUND;
                        state_next  = FSM_DONE;
                    end
                    else
                    begin
                        state_next = FSM_HASH;
                    end
                end
            end
            FSM_HASH:
            begin
                // start on entry: the key register is loaded by then
                div_start = (i_reg != SIZE_W'(0));
                if (div_done)
                begin
                    div_start  = 1'b0;
                    p_next     = div_rem;
                    d_next     = (n_act == SIZE_W'(1)) ? '0 : SIZE_W'(1);
                    i_next     = '0;
                    state_next = FSM_READ;
                end
            end
            FSM_READ:
            begin
                if (i_reg == n_act)
                begin
                    res_st_next = ST_LIMIT;
                    state_next  = FSM_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = FSM_CHECK;
                end
            end
            FSM_CHECK:
            begin
                state_next = FSM_DONE;
                if (op_mode_reg == MODE_INSERT)
                begin
                    if (!ram_rdata.used)
                    begin
                        ram_we      = 1'b1;
                        used_next   = used_reg + SIZE_W'(1);
                        res_st_next = ST_NEW;
                    end
                    else if (ram_rdata.key == op_key_reg)
                    begin
                        ram_we      = 1'b1;
                        res_st_next = ST_UPDATED;
                    end
                    else
                    begin
                        if (coll_reg != '1)
                            coll_next = coll_reg + CNT_W'(1);
                        state_next = FSM_READ;
                    end
                end
                else
                begin
                    if (!ram_rdata.used)
                    begin
                        res_st_next = ST_NOTFOUND;
                    end
                    else if (ram_rdata.key == op_key_reg)
                    begin
                        if (op_mode_reg == MODE_DELETE)
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = '{used: 1'b0, key: '0, value: '0};
                            if (used_reg != '0)
                                used_next = used_reg - SIZE_W'(1);
                            res_st_next = ST_DELETED;
                        end
                        else
                        begin
                            res_val_next = ram_rdata.value;
                            res_st_next  = ST_FOUND;
                        end
                    end
                    else
                    begin
                        state_next = FSM_READ;
                    end
                end
                if (state_next == FSM_READ)
                begin
                    // advance: next square offset is the previous plus 2i+1
                    if (p_sum >= {1'b0, n_act})
                        p_next = SIZE_W'(p_sum - {1'b0, n_act});
                    else
                        p_next = p_sum[SIZE_W-1:0];
                    if (n_act == SIZE_W'(1))
                        d_next = '0;
                    else if (d_sum >= {1'b0, n_act})
                        d_next = SIZE_W'(d_sum - {1'b0, n_act});
                    else
                        d_next = d_sum[SIZE_W-1:0];
                    i_next = i_reg + SIZE_W'(1);
                end
            end
            FSM_DONE:
            begin
                // hold until the output register is free
                if (!ov_reg || out_ready)
                begin
                    o_load     = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        // mark the divider start with i: one-shot on entry to hashing
        if (state_reg == FSM_IDLE)
            i_next = SIZE_W'(1);
        else if (state_reg == FSM_HASH && div_start)
            i_next = '0;

        ov_next = ov_reg;
        if (o_load)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLEAR;
            clr_reg   <= '0;
            size_reg  <= TABLE_SIZE_RST;
            used_reg  <= '0;
            coll_reg  <= '0;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we)
                size_reg <= cfg_data;
            used_reg  <= used_next;
            coll_reg  <= coll_next;
            ov_reg    <= ov_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg <= op_mode_next;
        op_key_reg  <= op_key_next;
        op_val_reg  <= op_val_next;
        p_reg       <= p_next;
        d_reg       <= d_next;
        res_st_reg  <= res_st_next;
        res_val_reg <= res_val_next;
        if (o_load)
        begin
            o_st_reg   <= res_st_next;
            o_val_reg  <= res_val_next;
            o_coll_reg <= coll_next;
            o_occ_reg  <= used_next;
        end
    end

    assign out_valid       = ov_reg;
    assign status          = o_st_reg;
    assign value_out       = o_val_reg;
    assign collision_count = o_coll_reg;
    assign occupancy       = o_occ_reg;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks quadratic_probe_hash_table. A local copy of the table predicts
// every result, and a directed table covers reset state and extremes. Many
// table sizes follow, each with a random mix of operations. Both channels
// pause at random, and one long receiver hold-off stalls the block.
// ----------------------------------------------------------------------------
module testbench;

    import qph_pkg::*;

    localparam int TBL_SLOTS = SLOTS_DEF;
    localparam int NUM_SIZES = 10;

    typedef struct packed {
        logic [2:0]        status;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  coll;
        logic [SIZE_W-1:0] occ;
    } hash_result_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic              typed;
        hash_result_t      want;
    } op_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [SIZE_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          mode;
    logic [KEY_W-1:0]    key_in;
    logic signed [VAL_W-1:0] value_in;
    logic                out_valid;
    logic                out_ready;
    logic [2:0]          status;
    logic signed [VAL_W-1:0] value_out;
    logic [CNT_W-1:0]    collision_count;
    logic [SIZE_W-1:0]   occupancy;

    // Shadow copy of the table
    logic                shadow_used [TBL_SLOTS];
    logic [KEY_W-1:0]    shadow_key  [TBL_SLOTS];
    logic [VAL_W-1:0]    shadow_val  [TBL_SLOTS];
    int unsigned         shadow_count;
    logic [CNT_W-1:0]    shadow_coll;
    logic [SIZE_W-1:0]   shadow_size;

    hash_result_t        pending_results [$];
    op_row_t             directed_rows [$];
    logic [KEY_W-1:0]    key_pool [$];

    int                  mismatches;
    int                  ops_sent;
    int                  results_seen;
    int                  status_seen [8];
    bit                  quiet;       // no idling on either side
    bit                  hold_req;    // ask the receiver for one long hold-off

    quadratic_probe_hash_table u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .key_in          (key_in),
        .value_in        (value_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .value_out       (value_out),
        .collision_count (collision_count),
        .occupancy       (occupancy)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Size actually used for hashing: zero acts as one, oversize is clamped
    function automatic int live_size();
        int n;
        n = int'(shadow_size);
        if (n == 0)
            n = 1;
        if (n > TBL_SLOTS)
            n = TBL_SLOTS;
        return n;
    endfunction

    function automatic int probe_slot(int home, int step, int n);
        return int'((longint'(home) + longint'(step) * longint'(step)) % n);
    endfunction

    // Apply one operation to the shadow table and return the result it gives
    function automatic hash_result_t hash_apply(logic [1:0] op, logic [KEY_W-1:0] k,
                                                logic [VAL_W-1:0] v);
        hash_result_t r;
        int n;
        int home;
        int p;
        n    = live_size();
        home = int'(longint'(k) % n);
        r.status = ST_NOTFOUND;
        r.value  = '0;
        if (op == MODE_INSERT)
        begin
            if (shadow_count >= n)
                r.status = ST_FULL;
            else
            begin
                r.status = ST_LIMIT;
                for (int i = 0; i < n; i++)
                begin
                    p = probe_slot(home, i, n);
                    if (!shadow_used[p])
                    begin
                        shadow_used[p] = 1'b1;
                        shadow_key[p]  = k;
                        shadow_val[p]  = v;
                        shadow_count++;
                        r.status = ST_NEW;
                        break;
                    end
                    if (shadow_key[p] == k)
                    begin
                        shadow_val[p] = v;
                        r.status = ST_UPDATED;
                        break;
                    end
                    if (shadow_coll != '1)
                        shadow_coll++;
                end
            end
        end
        else if (op == MODE_DELETE || op == MODE_LOOKUP)
        begin
            r.status = ST_LIMIT;
            for (int i = 0; i < n; i++)
            begin
                p = probe_slot(home, i, n);
                if (!shadow_used[p])
                begin
                    r.status = ST_NOTFOUND;
                    break;
                end
                if (shadow_key[p] == k)
                begin
                    if (op == MODE_DELETE)
                    begin
                        shadow_used[p] = 1'b0;
                        if (shadow_count > 0)
                            shadow_count--;
                        r.status = ST_DELETED;
                    end
                    else
                    begin
                        r.value  = shadow_val[p];
                        r.status = ST_FOUND;
                    end
                    break;
                end
            end
        end
        r.coll = shadow_coll;
        r.occ  = SIZE_W'(shadow_count);
        return r;
    endfunction

    // Offer one operation and hold it until transferred, then log what it owes
    task automatic offer_op(op_row_t row);
        hash_result_t r;
        mode     <= row.op;
        key_in   <= row.key;
        value_in <= row.value;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        r = hash_apply(row.op, row.key, row.value);
        if (row.typed)
            r = row.want;
        pending_results.push_back(r);
        ops_sent++;
    endtask

    // Transfer done: drop valid for a random gap, or keep it up for the next
    task automatic sender_gap();
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_row(op_row_t row);
        offer_op(row);
        sender_gap();
    endtask

    // Wait for every owed result; the block is idle once the last has left
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] sz);
        cfg_we   <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        cfg_we   <= 1'b0;
        shadow_size = sz;
        @(posedge clk);
    endtask

    function automatic op_row_t make_row(logic [1:0] op, logic [KEY_W-1:0] k,
                                         logic [VAL_W-1:0] v);
        op_row_t row;
        row.op    = op;
        row.key   = k;
        row.value = v;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic op_row_t make_typed(logic [1:0] op, logic [KEY_W-1:0] k,
                                           logic [VAL_W-1:0] v, logic [2:0] st,
                                           logic [VAL_W-1:0] vo, logic [SIZE_W-1:0] oc);
        op_row_t row;
        row = make_row(op, k, v);
        row.typed       = 1'b1;
        row.want.status = st;
        row.want.value  = vo;
        row.want.coll   = '0;
        row.want.occ    = oc;
        return row;
    endfunction

    // Delete every reachable key, farthest along its probe chain first, so
    // that clearing a slot does not cut off a key stored further along
    task automatic drain_table();
        int n;
        int home;
        int chain_pos [TBL_SLOTS];
        n = live_size();
        for (int s = 0; s < n; s++)
        begin
            chain_pos[s] = -1;
            if (shadow_used[s])
            begin
                home = int'(longint'(shadow_key[s]) % n);
                for (int i = 0; i < n; i++)
                    if (probe_slot(home, i, n) == s)
                    begin
                        chain_pos[s] = i;
                        break;
                    end
            end
        end
        for (int d = n - 1; d >= 0; d--)
            for (int s = 0; s < n; s++)
                if (chain_pos[s] == d && shadow_used[s])
                    send_row(make_row(MODE_DELETE, shadow_key[s], $urandom));
    endtask

    // Random mix over a small key pool, so that matches, full and probe
    // limit all turn up; a few keys come fresh from the whole range
    task automatic random_phase(int count);
        int n;
        int pick;
        int pool_len;
        logic [1:0] op;
        logic [KEY_W-1:0] k;
        n = live_size();
        pool_len = (n + n / 2 + 2 > 48) ? 48 : n + n / 2 + 2;
        key_pool.delete();
        for (int i = 0; i < pool_len; i++)
            key_pool.push_back(KEY_W'($urandom));
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = MODE_INSERT;
            else if (pick < 70)
                op = MODE_LOOKUP;
            else if (pick < 95)
                op = MODE_DELETE;
            else
                op = MODE_UNUSED;
            if ($urandom_range(0, 49) == 0)
                k = KEY_W'($urandom);
            else
                k = key_pool[$urandom_range(0, pool_len - 1)];
            send_row(make_row(op, k, $urandom));
        end
    endtask

    // Receiver: random stalls, one long hold-off on request, check in order
    initial
    begin
        hash_result_t want;
        hash_result_t got;
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 12);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = 400;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got.status = status;
            got.value  = value_out;
            got.coll   = collision_count;
            got.occ    = occupancy;
            results_seen++;
            status_seen[got.status]++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d value %0d coll %0d occ %0d",
                             got.status, $signed(got.value), got.coll, got.occ);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("result %0d: exp st %0d val %0d coll %0d occ %0d, ",
                               results_seen, want.status, $signed(want.value), want.coll,
                               want.occ);
                        $display("got st %0d val %0d coll %0d occ %0d",
                                 got.status, $signed(got.value), got.coll, got.occ);
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [SIZE_W-1:0] sizes [NUM_SIZES];
        sizes = '{SIZE_W'(1), SIZE_W'(0), SIZE_W'(3), SIZE_W'(8), SIZE_W'(13),
                  SIZE_W'(64), SIZE_W'(100), SIZE_W'(1024), SIZE_W'(2047), SIZE_W'(37)};
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode     = MODE_INSERT;
        key_in   = '0;
        value_in = '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        mismatches   = 0;
        ops_sent     = 0;
        results_seen = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (shadow_used[i])
        begin
            shadow_used[i] = 1'b0;
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
        end
        shadow_count = 0;
        shadow_coll  = '0;
        shadow_size  = TABLE_SIZE_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset size, the first rows read straight off the spec
        directed_rows.push_back(make_typed(MODE_INSERT, '0, 32'd5, ST_NEW, '0, 11'd1));
        directed_rows.push_back(make_typed(MODE_LOOKUP, '0, '0, ST_FOUND, 32'd5, 11'd1));
        directed_rows.push_back(make_typed(MODE_LOOKUP, 31'd7, '1, ST_NOTFOUND, '0, 11'd1));
        directed_rows.push_back(make_typed(MODE_UNUSED, '0, '1, ST_NOTFOUND, '0, 11'd1));
        directed_rows.push_back(make_typed(MODE_INSERT, '0, 32'd9, ST_UPDATED, '0, 11'd1));
        directed_rows.push_back(make_row(MODE_INSERT, 31'd1024, 32'hFFFF_FFFF));
        directed_rows.push_back(make_row(MODE_INSERT, 31'd2048, 32'h8000_0000));
        directed_rows.push_back(make_row(MODE_DELETE, '0, '0));
        // chain broken by the delete: both later keys are lost to lookup
        directed_rows.push_back(make_row(MODE_LOOKUP, 31'd2048, '0));
        directed_rows.push_back(make_row(MODE_LOOKUP, 31'd1024, '0));
        directed_rows.push_back(make_row(MODE_INSERT, 31'h7FFF_FFFF, 32'h8000_0000));
        directed_rows.push_back(make_row(MODE_LOOKUP, 31'h7FFF_FFFF, '0));
        directed_rows.push_back(make_row(MODE_INSERT, 31'h5555_5555, 32'h7FFF_FFFF));
        directed_rows.push_back(make_row(MODE_INSERT, 31'h2AAA_AAAA, 32'h5555_AAAA));
        directed_rows.push_back(make_row(MODE_LOOKUP, 31'h2AAA_AAAA, '0));
        directed_rows.push_back(make_row(MODE_DELETE, 31'd5, '0));
        directed_rows.push_back(make_row(MODE_UNUSED, 31'h7FFF_FFFF, '1));
        directed_rows.push_back(make_row(MODE_DELETE, 31'h7FFF_FFFF, '0));
        foreach (directed_rows[i])
            send_row(directed_rows[i]);
        settle();
        drain_table();
        settle();

        foreach (sizes[s])
        begin
            write_size(sizes[s]);
            quiet = (s == 4);
            if (sizes[s] == SIZE_W'(64))
                hold_req = 1'b1;
            random_phase(175);
            settle();
            if (sizes[s] == SIZE_W'(64))
            begin
                // shrink while filled: entries beyond the new size stay put
                write_size(SIZE_W'(5));
                random_phase(40);
                settle();
                write_size(SIZE_W'(64));
            end
            drain_table();
            settle();
        end

        repeat (50) @(posedge clk);
        $display("%0d operations over %0d table sizes, %0d results checked",
                 ops_sent, NUM_SIZES + 2, results_seen);
        $display("status mix: new %0d upd %0d full %0d del %0d miss %0d hit %0d limit %0d",
                 status_seen[ST_NEW], status_seen[ST_UPDATED], status_seen[ST_FULL],
                 status_seen[ST_DELETED], status_seen[ST_NOTFOUND], status_seen[ST_FOUND],
                 status_seen[ST_LIMIT]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8ms;
        $display("timeout after %0d operations", ops_sent);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
